/* hw/rtl/gdaw_pkg.sv */
// ----------------------------------------------------------------------------
// gdaw_pkg
// Shared widths, calendar constants, types and helper functions for the
// Gregorian date add / weekday block.
// ----------------------------------------------------------------------------
package gdaw_pkg;

   // field widths
   localparam int YEAR_W    = 14;
   localparam int MONTH_W   = 4;
   localparam int DAY_W     = 5;
   localparam int OFF_W     = 13;
   localparam int WDAY_W    = 3;

   // year split into century and year-of-century
   localparam int CEN_W     = 8;
   localparam int REM_W     = 7;

   // running day accumulator, signed
   localparam int DAY_ACC_W = 14;
   localparam int DAY_PAD   = DAY_ACC_W - DAY_W;

   localparam int YEAR_MAX  = 9999;
   localparam int CENTURY   = 100;
   localparam int REM_MAX   = CENTURY - 1;

   // x / 100 == (x * 5243) >> 19 for x < 43699
   localparam int RECIP_100    = 5243;
   localparam int RECIP_100_SH = 19;
   localparam int SPLIT_PROD_W = YEAR_W + RECIP_100_SH - 6;

   // x / 7 == (x * 586) >> 12 for x < 683
   localparam int DAYS_PER_WEEK = 7;
   localparam int RECIP_7       = 586;
   localparam int RECIP_7_SH    = 12;
   localparam int ZSUM_W        = 10;
   localparam int ZMOD_W        = 9;
   localparam int ZPROD_W       = ZMOD_W + 10;
   localparam int ZQ_W          = ZPROD_W - RECIP_7_SH;
   localparam int ZELLER_BIAS   = 28 * DAYS_PER_WEEK;

   // month and weekday codes
   localparam int JANUARY  = 1;
   localparam int FEBRUARY = 2;
   localparam int MARCH    = 3;
   localparam int DECEMBER = 12;
   localparam int SUNDAY   = 0;
   localparam int SATURDAY = 6;

   localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   typedef struct packed {
      logic [CEN_W-1:0] cen;
      logic [REM_W-1:0] rem;
   } year_split_type;

   typedef struct packed {
      logic [CEN_W-1:0]   cen;
      logic [REM_W-1:0]   rem;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } date_pos_type;

   // leap test on a split year: year % 4 equals rem % 4
   function automatic logic is_leap_f(input logic [REM_W-1:0] rem,
                                      input logic [CEN_W-1:0] cen);
      is_leap_f = ((rem[1:0] == 2'b00) && (rem != '0)) ||
                  ((rem == '0) && (cen[1:0] == 2'b00));
   endfunction

   function automatic logic [DAY_W-1:0] month_len_f(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
      logic [MONTH_W-1:0] idx;
      idx = month - MONTH_W'(JANUARY);
      if ((month == MONTH_W'(FEBRUARY)) && leap)
         month_len_f = DAY_W'(29);
      else if ((month == '0) || (month > MONTH_W'(DECEMBER)))
         month_len_f = DAY_W'(31);
      else
         month_len_f = MONTH_LEN[idx];
   endfunction

   // (13 * (mm + 1)) / 5 for the shifted month 3..14
   function automatic logic [5:0] zeller_month_term_f(input logic [MONTH_W-1:0] mm);
      case (mm)
         4'd3:    zeller_month_term_f = 6'd10;
         4'd4:    zeller_month_term_f = 6'd13;
         4'd5:    zeller_month_term_f = 6'd15;
         4'd6:    zeller_month_term_f = 6'd18;
         4'd7:    zeller_month_term_f = 6'd20;
         4'd8:    zeller_month_term_f = 6'd23;
         4'd9:    zeller_month_term_f = 6'd26;
         4'd10:   zeller_month_term_f = 6'd28;
         4'd11:   zeller_month_term_f = 6'd31;
         4'd12:   zeller_month_term_f = 6'd33;
         4'd13:   zeller_month_term_f = 6'd36;
         4'd14:   zeller_month_term_f = 6'd39;
         default: zeller_month_term_f = 6'd0;
      endcase
   endfunction

endpackage

/* hw/rtl/gdaw_year_split.sv */
// ----------------------------------------------------------------------------
// gdaw_year_split
// Splits a year into century and year-of-century with a reciprocal multiply.
// Registered output.
// ----------------------------------------------------------------------------
module gdaw_year_split (
   input  logic                          clock,
   input  logic [gdaw_pkg::YEAR_W-1:0]   year,
   output gdaw_pkg::year_split_type      split
);
   import gdaw_pkg::*;

   logic [SPLIT_PROD_W-1:0] prod;
   logic [CEN_W-1:0]        cen;
   logic [YEAR_W-1:0]       rem_full;
   year_split_type          split_ff;
   year_split_type          split_in;

   always_comb begin
      prod     = SPLIT_PROD_W'(year) * SPLIT_PROD_W'(RECIP_100);
      cen      = prod[SPLIT_PROD_W-1:RECIP_100_SH];
      rem_full = year - YEAR_W'(YEAR_W'(cen) * YEAR_W'(CENTURY));
      split_in.cen = cen;
      split_in.rem = rem_full[REM_W-1:0];
   end

   always_ff @(posedge clock) begin
      split_ff <= split_in;
   end

   assign split = split_ff;

endmodule

/* hw/rtl/gdaw_weekday.sv */
// ----------------------------------------------------------------------------
// gdaw_weekday
// Zeller's congruence, two register stages: biased sum, then mod 7 by
// reciprocal multiply. 0 is Sunday.
// ----------------------------------------------------------------------------
module gdaw_weekday (
   input  logic                          clock,
   input  gdaw_pkg::date_pos_type        pos,
   output logic [gdaw_pkg::WDAY_W-1:0]   weekday
);
   import gdaw_pkg::*;

   logic [MONTH_W-1:0] mm;
   logic [REM_W-1:0]   yr;
   logic [CEN_W-1:0]   cn;
   logic [ZSUM_W-1:0]  sum;
   logic [ZMOD_W-1:0]  x_ff;
   logic [ZMOD_W-1:0]  x_in;
   logic [ZPROD_W-1:0] prod;
   logic [ZQ_W-1:0]    q;
   logic [ZMOD_W-1:0]  r_full;
   logic [WDAY_W-1:0]  r;
   logic [WDAY_W-1:0]  weekday_ff;
   logic [WDAY_W-1:0]  weekday_in;

   // January and February count as months 13 and 14 of the prior year
   always_comb begin
      if (pos.month < MONTH_W'(MARCH)) begin
         mm = pos.month + MONTH_W'(12);
         if (pos.rem == '0) begin
            yr = REM_W'(REM_MAX);
            cn = pos.cen - CEN_W'(1);
         end else begin
            yr = pos.rem - REM_W'(1);
            cn = pos.cen;
         end
      end else begin
         mm = pos.month;
         yr = pos.rem;
         cn = pos.cen;
      end
      // bias by a multiple of 7 keeps the sum positive
      sum = ZSUM_W'(ZELLER_BIAS) + ZSUM_W'(pos.day) + ZSUM_W'(zeller_month_term_f(mm))
          + ZSUM_W'(yr) + ZSUM_W'(yr >> 2) + ZSUM_W'(cn >> 2) - ZSUM_W'({cn, 1'b0});
      x_in = sum[ZMOD_W-1:0];
   end

   always_comb begin
      prod   = ZPROD_W'(x_ff) * ZPROD_W'(RECIP_7);
      q      = prod[ZPROD_W-1:RECIP_7_SH];
      r_full = x_ff - ZMOD_W'(ZMOD_W'(q) * ZMOD_W'(DAYS_PER_WEEK));
      r      = r_full[WDAY_W-1:0];
      // congruence gives 0 for Saturday; rotate to 0 for Sunday
      weekday_in = (r == '0) ? WDAY_W'(SATURDAY) : (r - WDAY_W'(1));
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      weekday_ff <= weekday_in;
   end

   assign weekday = weekday_ff;

endmodule

/* hw/rtl/gregorian_date_add_days_weekday.sv */
// ----------------------------------------------------------------------------
// gregorian_date_add_days_weekday
// Adds a signed day count to a Gregorian date and reports weekday and leap.
// ----------------------------------------------------------------------------
// One transaction at a time. A request passes through fixed steps (accept,
// year split, load, the final check of the walk in each direction, two
// weekday stages, result load) plus one step per month boundary crossed:
// the walk steps one month per cycle through a single day adder that
// subtracts the current month length forward or adds the previous one back.
// The largest offsets cross about 137 months; req_stall stays high
// until the result is loaded into the output register. The result register
// lets a finished transaction wait on rsp_stall while the next request is
// taken. If the walk leaves years 1..9999, or the start year or month is
// invalid, the start date is returned with rsp_range_error set; for an
// invalid start the weekday reads 0.
// ----------------------------------------------------------------------------
module gregorian_date_add_days_weekday (
   input  logic                                 clock,
   input  logic                                 reset,
   // request
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [gdaw_pkg::YEAR_W-1:0]          req_start_year,
   input  logic [gdaw_pkg::MONTH_W-1:0]         req_start_month,
   input  logic [gdaw_pkg::DAY_W-1:0]           req_start_day,
   input  logic signed [gdaw_pkg::OFF_W-1:0]    req_day_offset,
   // response
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [gdaw_pkg::YEAR_W-1:0]          rsp_end_year,
   output logic [gdaw_pkg::MONTH_W-1:0]         rsp_end_month,
   output logic [gdaw_pkg::DAY_W-1:0]           rsp_end_day,
   output logic [gdaw_pkg::WDAY_W-1:0]          rsp_weekday,
   output logic                                 rsp_leap,
   output logic                                 rsp_range_error
);
   import gdaw_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SPLIT,    // year split register filling
      S_LOAD,     // validate start, seed walk registers
      S_FWD,      // walk forward while day is past month end
      S_BWD,      // walk back while day is below 1
      S_WD1,      // weekday sum stage
      S_WD2,      // weekday mod stage
      S_FINISH    // wait for free output register
   } state_type;

   state_type state_ff, state_in;

   // captured request
   logic [YEAR_W-1:0]       start_year_ff,  start_year_in;
   logic [MONTH_W-1:0]      start_month_ff, start_month_in;
   logic [DAY_W-1:0]        start_day_ff,   start_day_in;
   logic [OFF_W-1:0]        day_offset_ff,  day_offset_in;

   // walk state: year kept as binary plus century / year-of-century
   logic [YEAR_W-1:0]       year_ff,  year_in;
   logic [CEN_W-1:0]        cen_ff,   cen_in;
   logic [REM_W-1:0]        rem_ff,   rem_in;
   logic [MONTH_W-1:0]      month_ff, month_in;
   logic [DAY_ACC_W-1:0]    day_ff,   day_in;
   logic                    err_ff,   err_in;
   logic                    bad_ff,   bad_in;

   // output register
   logic                    rsp_valid_ff,   rsp_valid_in;
   logic [YEAR_W-1:0]       end_year_ff,    end_year_in;
   logic [MONTH_W-1:0]      end_month_ff,   end_month_in;
   logic [DAY_W-1:0]        end_day_ff,     end_day_in;
   logic [WDAY_W-1:0]       weekday_ff,     weekday_in;
   logic                    leap_ff,        leap_in;
   logic                    range_error_ff, range_error_in;

   year_split_type          start_split;
   date_pos_type            wd_pos;
   logic [WDAY_W-1:0]       wd_result;

   logic                    accept;
   logic                    start_bad;
   logic [DAY_ACC_W-1:0]    day_init;
   logic                    cur_leap;
   logic [DAY_W-1:0]        cur_len;
   logic [MONTH_W-1:0]      prev_month;
   logic [YEAR_W-1:0]       prev_year;
   logic [CEN_W-1:0]        prev_cen;
   logic [REM_W-1:0]        prev_rem;
   logic [DAY_W-1:0]        prev_len;
   logic                    step_sub;
   logic [DAY_ACC_W-1:0]    step_opnd;
   logic [DAY_ACC_W-1:0]    day_sum;
   logic                    day_past_end;
   logic                    day_below_one;
   logic                    restore;

   gdaw_year_split u_year_split (
      .clock (clock),
      .year  (start_year_ff),
      .split (start_split)
   );

   // cen, rem, month, day
   assign wd_pos = {cen_ff, rem_ff, month_ff, day_ff[DAY_W-1:0]};

   gdaw_weekday u_weekday (
      .clock   (clock),
      .pos     (wd_pos),
      .weekday (wd_result)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      start_bad = (start_year_ff == '0) || (start_year_ff > YEAR_W'(YEAR_MAX)) ||
                  (start_month_ff == '0) || (start_month_ff > MONTH_W'(DECEMBER));
      day_init  = DAY_ACC_W'(start_day_ff) +
                  {{(DAY_ACC_W-OFF_W){day_offset_ff[OFF_W-1]}}, day_offset_ff};

      cur_leap  = is_leap_f(rem_ff, cen_ff);
      cur_len   = month_len_f(month_ff, cur_leap);

      // previous month, for the backward walk
      if (month_ff == MONTH_W'(JANUARY)) begin
         prev_month = MONTH_W'(DECEMBER);
         prev_year  = year_ff - YEAR_W'(1);
         if (rem_ff == '0) begin
            prev_rem = REM_W'(REM_MAX);
            prev_cen = cen_ff - CEN_W'(1);
         end else begin
            prev_rem = rem_ff - REM_W'(1);
            prev_cen = cen_ff;
         end
      end else begin
         prev_month = month_ff - MONTH_W'(1);
         prev_year  = year_ff;
         prev_rem   = rem_ff;
         prev_cen   = cen_ff;
      end
      prev_len = month_len_f(prev_month, is_leap_f(prev_rem, prev_cen));

      // shared day adder: subtract current length forward, add previous back
      step_sub  = (state_ff == S_FWD);
      step_opnd = step_sub ? (~{{DAY_PAD{1'b0}}, cur_len} + DAY_ACC_W'(1))
                           : {{DAY_PAD{1'b0}}, prev_len};
      day_sum   = day_ff + step_opnd;

      day_past_end  = $signed(day_ff) > $signed({{DAY_PAD{1'b0}}, cur_len});
      day_below_one = day_ff[DAY_ACC_W-1] || (day_ff == '0);
   end

   always_comb begin
      state_in       = state_ff;
      start_year_in  = start_year_ff;
      start_month_in = start_month_ff;
      start_day_in   = start_day_ff;
      day_offset_in  = day_offset_ff;
      year_in        = year_ff;
      cen_in         = cen_ff;
      rem_in         = rem_ff;
      month_in       = month_ff;
      day_in         = day_ff;
      err_in         = err_ff;
      bad_in         = bad_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      end_year_in    = end_year_ff;
      end_month_in   = end_month_ff;
      end_day_in     = end_day_ff;
      weekday_in     = weekday_ff;
      leap_in        = leap_ff;
      range_error_in = range_error_ff;
      restore        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               start_year_in  = req_start_year;
               start_month_in = req_start_month;
               start_day_in   = req_start_day;
               day_offset_in  = req_day_offset;
               state_in       = S_SPLIT;
            end
         end
         S_SPLIT: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            year_in  = start_year_ff;
            cen_in   = start_split.cen;
            rem_in   = start_split.rem;
            month_in = start_month_ff;
            bad_in   = start_bad;
            err_in   = start_bad;
            if (start_bad) begin
               day_in   = DAY_ACC_W'(start_day_ff);
               state_in = S_FINISH;
            end else begin
               day_in   = day_init;
               state_in = S_FWD;
            end
         end
         S_FWD: begin
            if (day_past_end) begin
               day_in = day_sum;
               if (month_ff == MONTH_W'(DECEMBER)) begin
                  if (year_ff == YEAR_W'(YEAR_MAX)) begin
                     restore = 1'b1;
                  end else begin
                     month_in = MONTH_W'(JANUARY);
                     year_in  = year_ff + YEAR_W'(1);
                     if (rem_ff == REM_W'(REM_MAX)) begin
                        rem_in = '0;
                        cen_in = cen_ff + CEN_W'(1);
                     end else begin
                        rem_in = rem_ff + REM_W'(1);
                     end
                  end
               end else begin
                  month_in = month_ff + MONTH_W'(1);
               end
            end else begin
               state_in = S_BWD;
            end
         end
         S_BWD: begin
            if (day_below_one) begin
               if (prev_year == '0) begin
                  restore = 1'b1;
               end else begin
                  month_in = prev_month;
                  year_in  = prev_year;
                  cen_in   = prev_cen;
                  rem_in   = prev_rem;
                  day_in   = day_sum;
               end
            end else begin
               state_in = S_WD1;
            end
         end
         S_WD1: begin
            state_in = S_WD2;
         end
         S_WD2: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               end_year_in    = year_ff;
               end_month_in   = month_ff;
               end_day_in     = day_ff[DAY_W-1:0];
               weekday_in     = bad_ff ? WDAY_W'(SUNDAY) : wd_result;
               leap_in        = cur_leap;
               range_error_in = err_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // out of years: fall back to the start date and its weekday
      if (restore) begin
         year_in  = start_year_ff;
         cen_in   = start_split.cen;
         rem_in   = start_split.rem;
         month_in = start_month_ff;
         day_in   = DAY_ACC_W'(start_day_ff);
         err_in   = 1'b1;
         state_in = S_WD1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      start_year_ff  <= start_year_in;
      start_month_ff <= start_month_in;
      start_day_ff   <= start_day_in;
      day_offset_ff  <= day_offset_in;
      year_ff        <= year_in;
      cen_ff         <= cen_in;
      rem_ff         <= rem_in;
      month_ff       <= month_in;
      day_ff         <= day_in;
      err_ff         <= err_in;
      bad_ff         <= bad_in;
      end_year_ff    <= end_year_in;
      end_month_ff   <= end_month_in;
      end_day_ff     <= end_day_in;
      weekday_ff     <= weekday_in;
      leap_ff        <= leap_in;
      range_error_ff <= range_error_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_end_year    = end_year_ff;
   assign rsp_end_month   = end_month_ff;
   assign rsp_end_day     = end_day_ff;
   assign rsp_weekday     = weekday_ff;
   assign rsp_leap        = leap_ff;
   assign rsp_range_error = range_error_ff;

   // an accepted transaction always starts with the year split
   a_accept_split: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_SPLIT))
      else $error("accepted transaction did not enter year split");

   // the walk only ever sees a legal month and year
   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FWD) || (state_ff == S_BWD)) |->
         ((month_ff >= MONTH_W'(JANUARY)) && (month_ff <= MONTH_W'(DECEMBER)) &&
          (year_ff != '0) && (year_ff <= YEAR_W'(YEAR_MAX))))
      else $error("walk left legal month or year");

   // a good result is a real day of its month
   a_day_in_month: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_range_error) |->
         ((rsp_end_day != '0) &&
          (rsp_end_day <= month_len_f(rsp_end_month, rsp_leap))))
      else $error("result day outside its month");

   a_weekday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_weekday <= WDAY_W'(SATURDAY)))
      else $error("weekday out of range");

endmodule
